FILE: sv/rtu_pkg.sv
// ----------------------------------------------------------------------------
// RTU frame receiver package
// Shared types and constants: result codes, receiver mode, register indexes.
// ----------------------------------------------------------------------------
package rtu_pkg;

	localparam int unsigned MIN_FRAME = 8;
	localparam int unsigned CFG_IDX_W = 1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_STATION_ADDRESS = 1'd0;
	localparam cfg_idx_t REG_SILENCE_TICKS   = 1'd1;

	localparam logic [7:0] STATION_ADDRESS_RST = 8'd1;
	localparam logic [7:0] SILENCE_TICKS_RST   = 8'd149;
	localparam logic [7:0] BROADCAST_ADDR      = 8'd0;
	localparam logic [7:0] SILENCE_MAX         = 8'd255;
	localparam logic [15:0] CRC_INIT           = 16'hFFFF;
	localparam logic [15:0] CRC_POLY           = 16'hA001;

	typedef enum logic [2:0] {
		EV_BYTE  = 3'd0,
		EV_OK    = 3'd1,
		EV_SHORT = 3'd2,
		EV_ADDR  = 3'd3,
		EV_CRC   = 3'd4,
		EV_ABORT = 3'd5
	} event_t;

	typedef enum logic [2:0] {
		MODE_RESYNC = 3'b001,
		MODE_IDLE   = 3'b010,
		MODE_RX     = 3'b100
	} mode_t;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

endpackage

FILE: sv/rtu_if.sv
// ----------------------------------------------------------------------------
// RTU frame receiver channels
// Valid/ready channels for received items, results and register writes.
// ----------------------------------------------------------------------------
interface rtu_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] rx_byte;
	logic       framing_error;
	logic       parity_error;

	modport source (output valid, command, rx_byte, framing_error, parity_error,
		input ready);
	modport sink (input valid, command, rx_byte, framing_error, parity_error,
		output ready);
endinterface

interface rtu_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic [7:0] byte_value;
	logic [7:0] byte_index;
	logic [8:0] frame_length;

	modport source (output valid, event_res, byte_value, byte_index, frame_length,
		input ready);
	modport sink (input valid, event_res, byte_value, byte_index, frame_length,
		output ready);
endinterface

interface rtu_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/rtu_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// RTU frame receiver core
// Takes received bytes and timer ticks one item per clock, unless stalled as
// below, and reports stored bytes and frame verdicts. An item is registered
// at the input stage; the item held there is handled combinationally, and its
// result, if any, is loaded into the output register when the item advances
// and is offered from there. A new item is accepted every cycle unless the
// registered item has a result while the result register is full and
// stalled. Items that give no result never wait on the output side.
// ----------------------------------------------------------------------------
module rtu_frame_receiver_core #(
	parameter int unsigned FRAME_CAPACITY = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	rtu_in_if.sink       rx,
	rtu_out_if.source    evt,
	rtu_cfg_if.sink      cfg
);
	import rtu_pkg::*;

	localparam int unsigned CNT_W = $clog2(FRAME_CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(FRAME_CAPACITY);
	localparam logic [CNT_W-1:0] MIN_LEN  = CNT_W'(MIN_FRAME);

	// configuration registers
	logic [7:0] station_address_q;
	logic [7:0] silence_ticks_q;

	// input stage
	logic       valid_s1;
	logic       command_s1;
	logic [7:0] rx_byte_s1;
	logic       err_s1;

	// receiver state
	mode_t            mode_q;
	logic [7:0]       silence_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       first_q;
	logic [15:0]      crc_q;

	// result register
	logic       out_valid_q;
	event_t     event_q;
	logic [7:0] value_q;
	logic [7:0] index_q;
	logic [8:0] length_q;

	// next-state logic
	mode_t            mode_d;
	logic [7:0]       silence_d;
	logic [CNT_W-1:0] count_d;
	logic [7:0]       first_d;
	logic [15:0]      crc_d;
	logic             res_d;
	event_t           event_d;
	logic [7:0]       value_d;
	logic [7:0]       index_d;
	logic [8:0]       length_d;

	logic [15:0] crc_upd;
	logic [7:0]  tick_cnt;
	logic        advance;

	rtu_crc16 u_crc (
		.crc      (crc_q),
		.data     (rx_byte_s1),
		.crc_next (crc_upd)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_address_q <= STATION_ADDRESS_RST;
			silence_ticks_q   <= SILENCE_TICKS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_STATION_ADDRESS: station_address_q <= cfg.data;
				REG_SILENCE_TICKS:   silence_ticks_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	assign tick_cnt = (silence_q == SILENCE_MAX) ? SILENCE_MAX : silence_q + 8'd1;

	always_comb begin
		mode_d    = mode_q;
		silence_d = silence_q;
		count_d   = count_q;
		first_d   = first_q;
		crc_d     = crc_q;
		res_d     = 1'b0;
		event_d   = EV_BYTE;
		value_d   = 8'd0;
		index_d   = 8'd0;
		length_d  = 9'd0;

		if (command_s1 == CMD_TICK) begin
			silence_d = tick_cnt;
			if (tick_cnt >= silence_ticks_q) begin
				unique case (mode_q)
					MODE_RESYNC: begin
						mode_d  = MODE_IDLE;
						count_d = '0;
						first_d = 8'd0;
						crc_d   = CRC_INIT;
					end
					MODE_RX: begin
						res_d    = 1'b1;
						length_d = 9'(count_q);
						priority if (count_q < MIN_LEN) begin
							event_d = EV_SHORT;
						end else if (first_q != station_address_q &&
								first_q != BROADCAST_ADDR) begin
							event_d = EV_ADDR;
						end else if (crc_q != 16'd0) begin
							event_d = EV_CRC;
						end else begin
							event_d = EV_OK;
						end
						mode_d  = MODE_IDLE;
						count_d = '0;
						first_d = 8'd0;
						crc_d   = CRC_INIT;
					end
					default: ;
				endcase
			end
		end else begin
			silence_d = 8'd0;
			if (mode_q != MODE_RESYNC) begin
				res_d = 1'b1;
				if (err_s1 || count_q >= CAPACITY) begin
					// drop the frame and wait for silence
					event_d  = EV_ABORT;
					length_d = 9'(count_q);
					mode_d   = MODE_RESYNC;
					count_d  = '0;
					first_d  = 8'd0;
					crc_d    = CRC_INIT;
				end else begin
					event_d = EV_BYTE;
					value_d = rx_byte_s1;
					index_d = 8'(count_q);
					if (count_q == '0) begin
						first_d = rx_byte_s1;
					end
					crc_d   = crc_upd;
					count_d = count_q + 1'b1;
					mode_d  = MODE_RX;
				end
			end
		end
	end

	// an item without a result never waits on the output side
	assign advance  = valid_s1 && (!res_d || !out_valid_q || evt.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			command_s1 <= rx.command;
			rx_byte_s1 <= rx.rx_byte;
			err_s1     <= rx.framing_error | rx.parity_error;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_RESYNC;
			silence_q <= 8'd0;
			count_q   <= '0;
			first_q   <= 8'd0;
			crc_q     <= CRC_INIT;
		end else if (advance) begin
			mode_q    <= mode_d;
			silence_q <= silence_d;
			count_q   <= count_d;
			first_q   <= first_d;
			crc_q     <= crc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_d) begin
			out_valid_q <= 1'b1;
		end else if (evt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_d) begin
			event_q  <= event_d;
			value_q  <= value_d;
			index_q  <= index_d;
			length_q <= length_d;
		end
	end

	assign evt.valid        = out_valid_q;
	assign evt.event_res    = event_q;
	assign evt.byte_value   = value_q;
	assign evt.byte_index   = index_q;
	assign evt.frame_length = length_q;

endmodule

FILE: sv/rtu_crc16.sv
// ----------------------------------------------------------------------------
// RTU CRC-16 byte update
// Folds one byte into the reflected CRC-16 (polynomial 0xA001).
// ----------------------------------------------------------------------------
module rtu_crc16 (
	input  logic [15:0] crc,
	input  logic [7:0]  data,
	output logic [15:0] crc_next
);
	import rtu_pkg::*;

	always_comb begin
		logic [15:0] c;
		c = crc ^ {8'd0, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_next = c;
	end

endmodule
